// ----- hw/rtl/teq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int KIND_W  = 4;
    localparam int TAG_W   = 8;
    localparam int DELAY_W = 30;
    localparam int ELAP_W  = 20;
    localparam int STEP_W  = 24;
    localparam int TIME_W  = 32;
    localparam int MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CHANGE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] value;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/timed_event_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_queue
// Sorted queue of pending timed events with add, change, remove and tick.
// ----------------------------------------------------------------------------
// The input channel carries one command per transfer; the output channel
// carries fired events and full-queue drops, with last set on the final
// result of a command. A two-entry command queue lets the front accept
// commands while the back works on an earlier one; a command is held there
// until the back takes it.
// The back walks the list one entry per cycle while it does not wait on
// the output: an add searches for its place, a remove for its kind, a
// change removes its kind and inserts it anew, and a tick ages each entry
// and fires the due ones. Results leave from an output register; when the
// receiver stalls, the back waits while the front still fills its command
// queue. Reset empties the list and queues.
// ----------------------------------------------------------------------------
module timed_event_queue
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [KIND_W-1:0]  event_kind,
    input  wire logic [DELAY_W-1:0] delay_cycles,
    input  wire logic [ELAP_W-1:0]  elapsed_cycles,
    input  wire logic [TAG_W-1:0]   callback_tag,
    input  wire logic [STEP_W-1:0]  step_cycles,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    status,
    output logic [KIND_W-1:0]       fired_kind,
    output logic [TAG_W-1:0]        fired_tag,
    output logic                    last
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    teq_front u_front (
        .clk, .rst_n,
        .valid(in_valid), .ready(in_ready),
        .opcode, .event_kind, .delay_cycles, .elapsed_cycles,
        .callback_tag, .step_cycles,
        .cmd_valid, .cmd_ready, .cmd
    );

    teq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk, .rst_n,
        .cmd_valid, .cmd_ready, .cmd,
        .out_valid, .out_ready,
        .status, .fired_kind, .fired_tag, .last
    );

endmodule
`default_nettype wire

// ----- hw/rtl/teq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// teq_front
// Accepts input transfers, computes the event time or takes the tick step, and queues a command.
// ----------------------------------------------------------------------------
module teq_front
    import teq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [KIND_W-1:0]  event_kind,
    input  wire logic [DELAY_W-1:0] delay_cycles,
    input  wire logic [ELAP_W-1:0]  elapsed_cycles,
    input  wire logic [TAG_W-1:0]   callback_tag,
    input  wire logic [STEP_W-1:0]  step_cycles,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output cmd_t                    cmd
);

    cmd_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t in_cmd;
    logic push, pop;

    always_comb
    begin
        in_cmd.op   = op_t'(opcode);
        in_cmd.kind = event_kind;
        in_cmd.tag  = callback_tag;
        if (op_t'(opcode) == OP_TICK)
            in_cmd.value = {{(TIME_W-STEP_W){1'b0}}, step_cycles};
        else
            in_cmd.value = {2'b00, delay_cycles}
                         + {{(TIME_W-ELAP_W){1'b0}}, elapsed_cycles};
    end

    assign ready     = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = valid && ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/teq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// teq_back
// Holds the sorted event list and executes one command at a time.
// ----------------------------------------------------------------------------
module teq_back
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cmd_t              cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   status,
    output logic [KIND_W-1:0]      fired_kind,
    output logic [TAG_W-1:0]       fired_tag,
    output logic                   last
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int NOUT_W = $clog2(MAX_RESULTS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_INSERT = 5'b00100,
        S_TICK   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [TIME_W-1:0] time_reg [QUEUE_DEPTH];
    logic [KIND_W-1:0] kind_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_reg  [QUEUE_DEPTH];
    logic [CNT_W-1:0]  count_reg;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [NOUT_W-1:0] nout_reg;

    logic              ovalid_reg;
    logic              ostat_reg, olast_reg;
    logic [KIND_W-1:0] okind_reg;
    logic [TAG_W-1:0]  otag_reg;

    logic [IDX_W-1:0]  ix;
    logic              at_end;
    logic              hit_kind;
    logic              place;
    logic              due;
    logic              more_due;
    logic              full;
    logic              fire;
    logic              out_free;

    assign ix       = idx_reg[IDX_W-1:0];
    assign at_end   = (idx_reg >= count_reg);
    assign hit_kind = !at_end && (kind_reg[ix] == cmd_reg.kind);
    assign place    = at_end || (time_reg[ix] > cmd_reg.value);
    assign due      = !at_end && (time_reg[ix] <= cmd_reg.value);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign fire     = due && (nout_reg < NOUT_W'(MAX_RESULTS));
    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        more_due = 1'b0;
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            if (CNT_W'(j) > idx_reg && CNT_W'(j) < count_reg
                && time_reg[j] <= cmd_reg.value)
                more_due = 1'b1;
        end
    end

    assign cmd_ready  = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign status     = ostat_reg;
    assign fired_kind = okind_reg;
    assign fired_tag  = otag_reg;
    assign last       = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_ADD:  state_next = S_INSERT;
                        OP_TICK: state_next = S_TICK;
                        default: state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (at_end)
                    state_next = S_IDLE;
                else if (hit_kind)
                    state_next = (cmd_reg.op == OP_CHANGE) ? S_INSERT : S_IDLE;
            end
            S_INSERT:
            begin
                if (full)
                begin
                    if (out_free)
                        state_next = S_EMIT;
                end
                else if (place)
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (at_end)
                    state_next = S_IDLE;
                else if (fire && out_free)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ovalid_reg)
                    state_next = (cmd_reg.op == OP_TICK) ? S_TICK : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (state_reg == S_SCAN && hit_kind)
                count_reg <= count_reg - CNT_W'(1);
            if (state_reg == S_INSERT && !full && place)
                count_reg <= count_reg + CNT_W'(1);
            if (state_reg == S_TICK && fire && out_free)
                count_reg <= count_reg - CNT_W'(1);
            if (state_reg == S_EMIT && !ovalid_reg)
                ovalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= cmd;
                idx_reg  <= '0;
                nout_reg <= '0;
            end
            S_SCAN:
            begin
                if (hit_kind)
                begin
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                    begin
                        if (CNT_W'(j) >= idx_reg)
                        begin
                            time_reg[j] <= time_reg[j+1];
                            kind_reg[j] <= kind_reg[j+1];
                            tag_reg[j]  <= tag_reg[j+1];
                        end
                    end
                    cmd_reg.tag <= tag_reg[ix];
                    idx_reg     <= '0;
                end
                else
                    idx_reg <= idx_reg + CNT_W'(1);
            end
            S_INSERT:
            begin
                if (full)
                begin
                    if (out_free)
                    begin
                        ostat_reg <= 1'b1;
                        okind_reg <= cmd_reg.kind;
                        otag_reg  <= cmd_reg.tag;
                        olast_reg <= 1'b1;
                    end
                end
                else if (place)
                begin
                    for (int j = 1; j < QUEUE_DEPTH; j++)
                    begin
                        if (CNT_W'(j) > idx_reg)
                        begin
                            time_reg[j] <= time_reg[j-1];
                            kind_reg[j] <= kind_reg[j-1];
                            tag_reg[j]  <= tag_reg[j-1];
                        end
                    end
                    time_reg[ix] <= cmd_reg.value;
                    kind_reg[ix] <= cmd_reg.kind;
                    tag_reg[ix]  <= cmd_reg.tag;
                end
                else
                    idx_reg <= idx_reg + CNT_W'(1);
            end
            S_TICK:
            begin
                if (fire)
                begin
                    if (out_free)
                    begin
                        ostat_reg <= 1'b0;
                        okind_reg <= kind_reg[ix];
                        otag_reg  <= tag_reg[ix];
                        olast_reg <= !more_due
                                  || (nout_reg == NOUT_W'(MAX_RESULTS - 1));
                        nout_reg  <= nout_reg + NOUT_W'(1);
                        for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                        begin
                            if (CNT_W'(j) >= idx_reg)
                            begin
                                time_reg[j] <= time_reg[j+1];
                                kind_reg[j] <= kind_reg[j+1];
                                tag_reg[j]  <= tag_reg[j+1];
                            end
                        end
                    end
                end
                else if (!at_end)
                begin
                    time_reg[ix] <= due ? '0 : time_reg[ix] - cmd_reg.value;
                    idx_reg      <= idx_reg + CNT_W'(1);
                end
            end
            S_EMIT: ;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/teq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue.
// ----------------------------------------------------------------------------
module teq_checker
    import teq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              status,
    input wire logic [KIND_W-1:0] fired_kind,
    input wire logic [TAG_W-1:0]  fired_tag,
    input wire logic              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired_tag)
        && $stable(fired_kind) && $stable(status) && $stable(last))
        else $error("output changed while stalled");

    a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last)
        else $error("drop result without last");

    a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated without gap");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind timed_event_queue teq_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready,
    .status, .fired_kind, .fired_tag, .last
);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the timed event queue.
// ----------------------------------------------------------------------------
// A local copy of the sorted event list predicts each fired event and each
// full-queue drop. Directed tests run first, then random sequences of adds,
// changes, removes and ticks. Both sides of the block stall at random, except in one random run.
// ----------------------------------------------------------------------------
module testbench;
    import teq_pkg::*;

    localparam int DEPTH = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic             status;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic             last;
    } fired_t;

    typedef struct {
        logic [TIME_W-1:0] due;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = OP_ADD;
    logic [KIND_W-1:0] event_kind = '0;
    logic [DELAY_W-1:0] delay_cycles = '0;
    logic [ELAP_W-1:0] elapsed_cycles = '0;
    logic [TAG_W-1:0] callback_tag = '0;
    logic [STEP_W-1:0] step_cycles = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic status;
    logic [KIND_W-1:0] fired_kind;
    logic [TAG_W-1:0] fired_tag;
    logic last;

    pending_t event_list[$];
    fired_t expected_fired[$];
    int mismatch_count = 0;
    longint cycle_count = 0;
    bit stall_enable = 1'b1;

    timed_event_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .event_kind(event_kind), .delay_cycles(delay_cycles),
        .elapsed_cycles(elapsed_cycles), .callback_tag(callback_tag),
        .step_cycles(step_cycles),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .fired_kind(fired_kind), .fired_tag(fired_tag),
        .last(last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stall_enable || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void insert_sorted(logic [TIME_W-1:0] due, logic [KIND_W-1:0] kind,
                                          logic [TAG_W-1:0] tag);
        pending_t p;
        int pos;
        pos = 0;
        while (pos < event_list.size() && event_list[pos].due <= due)
            pos++;
        p.due = due;
        p.kind = kind;
        p.tag = tag;
        event_list.insert(pos, p);
    endfunction

    function automatic int find_kind(logic [KIND_W-1:0] kind);
        foreach (event_list[i])
            if (event_list[i].kind == kind)
                return i;
        return -1;
    endfunction

    function automatic void predict_queue(logic [1:0] op, logic [KIND_W-1:0] kind,
                                          logic [DELAY_W-1:0] delay, logic [ELAP_W-1:0] elap,
                                          logic [TAG_W-1:0] tag, logic [STEP_W-1:0] step);
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0] old_tag;
        fired_t f;
        int pos;
        int fired;
        int i;
        due = TIME_W'(delay) + TIME_W'(elap);
        fired = 0;
        case (op)
            OP_ADD:
            begin
                if (event_list.size() >= DEPTH)
                begin
                    f = '{1'b1, kind, tag, 1'b1};
                    expected_fired = {expected_fired, f};
                end
                else
                    insert_sorted(due, kind, tag);
            end
            OP_CHANGE:
            begin
                pos = find_kind(kind);
                if (pos >= 0)
                begin
                    old_tag = event_list[pos].tag;
                    event_list.delete(pos);
                    insert_sorted(due, kind, old_tag);
                end
            end
            OP_REMOVE:
            begin
                pos = find_kind(kind);
                if (pos >= 0)
                    event_list.delete(pos);
            end
            default:
            begin
                i = 0;
                while (i < event_list.size())
                begin
                    if (event_list[i].due <= TIME_W'(step))
                    begin
                        if (fired < MAX_RESULTS)
                        begin
                            f = '{1'b0, event_list[i].kind, event_list[i].tag, 1'b0};
                            expected_fired = {expected_fired, f};
                            fired++;
                            event_list.delete(i);
                        end
                        else
                        begin
                            event_list[i].due = '0;
                            i++;
                        end
                    end
                    else
                    begin
                        event_list[i].due -= TIME_W'(step);
                        i++;
                    end
                end
                if (fired > 0)
                    expected_fired[expected_fired.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    task automatic send_command(logic [1:0] op, logic [KIND_W-1:0] kind,
                                logic [DELAY_W-1:0] delay, logic [ELAP_W-1:0] elap,
                                logic [TAG_W-1:0] tag, logic [STEP_W-1:0] step);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        event_kind <= kind;
        delay_cycles <= delay;
        elapsed_cycles <= elap;
        callback_tag <= tag;
        step_cycles <= step;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_queue(op, kind, delay, elap, tag, step);
    endtask

    task automatic send_random_command(int add_weight, int short_delays);
        int r;
        logic [DELAY_W-1:0] delay;
        logic [ELAP_W-1:0] elap;
        logic [STEP_W-1:0] step;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < add_weight)
            op = OP_ADD;
        else if (r < add_weight + 15)
            op = OP_CHANGE;
        else if (r < add_weight + 25)
            op = OP_REMOVE;
        else
            op = OP_TICK;
        if (short_delays != 0)
        begin
            delay = DELAY_W'($urandom_range(0, 200));
            elap = ELAP_W'($urandom_range(0, 50));
            step = STEP_W'($urandom_range(0, 150));
        end
        else
        begin
            delay = DELAY_W'($urandom);
            elap = ELAP_W'($urandom);
            step = STEP_W'($urandom);
        end
        send_command(op, KIND_W'($urandom_range(0, 15)), delay, elap,
                     TAG_W'($urandom), step);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_fired.size() != 0)
            @(posedge clk);
        repeat (4 * DEPTH + 10) @(posedge clk);
    endtask

    task automatic flush_queue();
        send_command(OP_TICK, '0, '0, '0, '0, '1);
        send_command(OP_TICK, '0, '0, '0, '0, '1);
        while (event_list.size() != 0)
            send_command(OP_TICK, '0, '0, '0, '0, '1);
    endtask

    task automatic test_extremes();
        send_command(OP_ADD, 4'hF, '1, '1, 8'hFF, '0);
        send_command(OP_ADD, 4'h0, '0, '0, 8'h00, '0);
        send_command(OP_TICK, '0, '0, '0, '0, '0);
        send_command(OP_ADD, 4'h5, 30'h2AAAAAAA, 20'h55555, 8'hA5, '0);
        send_command(OP_ADD, 4'hA, 30'h15555555, 20'hAAAAA, 8'h5A, '0);
        send_command(OP_TICK, '0, '0, '0, '0, 24'hAAAAAA);
        send_command(OP_TICK, '0, '0, '0, '0, 24'h555555);
        flush_queue();
    endtask

    task automatic test_change_remove();
        send_command(OP_ADD, 4'h3, 30'd10, '0, 8'h11, '0);
        send_command(OP_ADD, 4'h3, 30'd10, '0, 8'h22, '0);
        send_command(OP_ADD, 4'h7, 30'd5, 20'd5, 8'h33, '0);
        send_command(OP_CHANGE, 4'h3, 30'd2, 20'd1, '0, '0);
        send_command(OP_CHANGE, 4'h9, 30'd1, '0, '0, '0);
        send_command(OP_REMOVE, 4'h8, '0, '0, '0, '0);
        send_command(OP_REMOVE, 4'h7, '0, '0, '0, '0);
        send_command(OP_TICK, '0, '0, '0, '0, 24'd2);
        send_command(OP_TICK, '0, '0, '0, '0, 24'd3);
        send_command(OP_TICK, '0, '0, '0, '0, 24'd10);
    endtask

    task automatic test_full_queue();
        for (int k = 0; k < DEPTH + 2; k++)
            send_command(OP_ADD, KIND_W'(k), DELAY_W'(k % 3), '0, TAG_W'(k + 100), '0);
        send_command(OP_TICK, '0, '0, '0, '0, 24'd5);
    endtask

    task automatic test_random(int count, int add_weight, int short_delays);
        for (int k = 0; k < count; k++)
            send_random_command(add_weight, short_delays);
        flush_queue();
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= (random_gap() == 0);
    end

    always @(posedge clk)
    begin
        fired_t got;
        fired_t want;
        cycle_count++;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, fired_kind, fired_tag, last};
            if (expected_fired.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_fired.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected status %0b kind %0h tag %0h last %0b,",
                                  " got status %0b kind %0h tag %0h last %0b"},
                                 want.status, want.kind, want.tag, want.last,
                                 got.status, got.kind, got.tag, got.last);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        test_extremes();
        test_change_remove();
        test_full_queue();
        wait_drained();
        test_random(180, 45, 1);
        test_random(130, 60, 1);
        stall_enable = 1'b0;
        test_random(50, 40, 1);
        stall_enable = 1'b1;
        test_random(50, 40, 0);
        if (mismatch_count == 0 && expected_fired.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/teq_pkg.sv
hw/rtl/teq_front.sv
hw/rtl/teq_back.sv
hw/rtl/timed_event_queue.sv
hw/rtl/teq_checker.sv
sim/testbench.sv
